// ===== rtl/pmva_pkg.sv =====
// Shared types, constants and helper functions for the performance mode vote arbiter.
// Used by pmva_vote and performance_mode_vote_arbiter; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pmva_pkg;

  localparam int DEF_NUM_USERS = 32;
  localparam int DEF_NUM_MODES = 4;

  localparam int USER_ID_W = 5;
  localparam int MODE_W = 2;
  localparam int LEVEL_W = 2;
  localparam int MODE_IDX_MAX_W = 4;

  typedef enum logic [2:0] {
    ST_SUCCESS    = 3'd0,
    ST_FAIL       = 3'd1,
    ST_JOINED     = 3'd2,
    ST_DOWNGRADED = 3'd3,
    ST_REMOVED    = 3'd4
  } status_t;

  typedef struct packed {
    status_t             status;
    logic                clock_update;
    logic [LEVEL_W-1:0]  clock_level;
    logic [MODE_W-1:0]   working_mode;
  } result_t;

  // Mode m runs at clock level m-1, saturated at level 2; mode none maps to level 0.
  function automatic logic [LEVEL_W-1:0] mode_level(input logic [MODE_IDX_MAX_W-1:0] mode);
    logic [LEVEL_W-1:0] lvl;
    if (mode == '0) begin
      lvl = '0;
    end else if (mode > MODE_IDX_MAX_W'(3)) begin
      lvl = LEVEL_W'(2);
    end else begin
      lvl = LEVEL_W'(mode - MODE_IDX_MAX_W'(1));
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pmva_vote.sv =====
// Mode bitmap, per-mode voter masks and the combinational arbitration rules.
// Depends on pmva_pkg for the status codes, the result struct and the level mapping.
`timescale 1ns / 1ps
`default_nettype none

module pmva_vote
  import pmva_pkg::*;
#(
  parameter int NUM_USERS = DEF_NUM_USERS,
  parameter int NUM_MODES = DEF_NUM_MODES
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic [USER_ID_W-1:0] user_id,
  input  wire logic [MODE_W-1:0]    wanted_mode,
  output result_t                   result
);

  localparam int MW = $clog2(NUM_MODES);

  logic [NUM_MODES-1:0] active_modes;
  logic [NUM_MODES-1:0] active_modes_next;
  logic [NUM_USERS-1:0] mode_voters [NUM_MODES];
  logic [NUM_USERS-1:0] mode_voters_next [NUM_MODES];

  logic [NUM_MODES-1:0] map;
  logic [NUM_MODES-1:0] down_map;
  logic [MW-1:0]        work;
  logic [MW-1:0]        want;
  logic [NUM_USERS-1:0] me;
  logic [NUM_USERS-1:0] old;
  logic                 req_ok;
  logic                 hit;
  logic                 only;

  function automatic logic [MW-1:0] top_mode(input logic [NUM_MODES-1:0] bits);
    logic [MW-1:0] m;
    m = '0;
    for (int i = 1; i < NUM_MODES; i++) begin
      if (bits[i]) begin
        m = MW'(i);
      end
    end
    return m;
  endfunction

  always_comb begin
    map    = active_modes | NUM_MODES'(1);
    work   = top_mode(map);
    want   = MW'(wanted_mode);
    me     = NUM_USERS'(1) << user_id;
    old    = mode_voters[work];
    hit    = |(old & me);
    only   = (old == me);
    req_ok = (wanted_mode != '0) && (32'(user_id) < NUM_USERS) &&
             (32'(wanted_mode) < NUM_MODES);

    down_map = map & ~(NUM_MODES'(1) << work);
    if (down_map == NUM_MODES'(1)) begin
      down_map = down_map | (NUM_MODES'(1) << want);
    end

    active_modes_next = map;
    for (int i = 0; i < NUM_MODES; i++) begin
      mode_voters_next[i] = mode_voters[i];
    end
    result.status       = ST_FAIL;
    result.clock_update = 1'b0;
    result.clock_level  = '0;

    if (req_ok) begin
      if (want > work) begin
        result.clock_update = 1'b1;
        result.clock_level  = mode_level(MODE_IDX_MAX_W'(want));
        if (hit) begin
          if (only && (work != '0)) begin
            active_modes_next[work] = 1'b0;
          end
          mode_voters_next[work] = old & ~me;
        end
        mode_voters_next[want]  = me;
        active_modes_next[want] = 1'b1;
        result.status           = ST_SUCCESS;
      end else if (want == work) begin
        mode_voters_next[work] = old | me;
        result.status          = ST_JOINED;
      end else if (hit) begin
        if (only) begin
          if ((map & ~(NUM_MODES'(1) << work)) == NUM_MODES'(1)) begin
            mode_voters_next[want] = me;
          end
          mode_voters_next[work] = '0;
          active_modes_next      = down_map;
          result.clock_update    = 1'b1;
          result.clock_level     = mode_level(MODE_IDX_MAX_W'(top_mode(down_map)));
          result.status          = ST_DOWNGRADED;
        end else begin
          mode_voters_next[work] = old & ~me;
          result.status          = ST_REMOVED;
        end
      end
    end

    active_modes_next[0] = 1'b1;
    result.working_mode  = MODE_W'(top_mode(active_modes_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_modes <= NUM_MODES'(1);
      for (int i = 0; i < NUM_MODES; i++) begin
        mode_voters[i] <= '0;
      end
    end else if (en) begin
      active_modes <= active_modes_next;
      for (int i = 0; i < NUM_MODES; i++) begin
        mode_voters[i] <= mode_voters_next[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/performance_mode_vote_arbiter.sv =====
// Performance mode vote arbiter top level: request register, arbitration core, result register.
// Depends on pmva_pkg and pmva_vote.
//
// Usage: each request transaction on the input channel (in_valid/in_ready) carries a user_id
// and a wanted_mode. The block arbitrates it against the active modes and the voter masks and
// returns one result transaction on the output channel (out_valid/out_ready) holding status,
// clock_update, clock_level and the new working_mode.
// The request is held in the request register; out_valid rises at the clock edge that loads
// the result register, which waits while that register holds an untaken result. The arbitration
// and the state update happen combinationally between the request register and the
// result register, so one transaction is accepted every cycle while the receiver keeps up.
// When the receiver stalls, the result register holds its transaction, one more request can
// wait in the request register, and in_ready then falls until the result is taken; no state
// changes while a request waits.
// Reset clears both registers' valid flags, sets the mode bitmap to mode none only and clears
// every voter mask; the first request may be presented in the cycle after reset is released.
`timescale 1ns / 1ps
`default_nettype none

module performance_mode_vote_arbiter
  import pmva_pkg::*;
#(
  parameter int NUM_USERS = DEF_NUM_USERS,
  parameter int NUM_MODES = DEF_NUM_MODES
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [USER_ID_W-1:0] user_id,
  input  wire logic [MODE_W-1:0]    wanted_mode,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [2:0]                status,
  output logic                      clock_update,
  output logic [LEVEL_W-1:0]        clock_level,
  output logic [MODE_W-1:0]         working_mode
);

  logic                 req_valid;
  logic [USER_ID_W-1:0] req_user;
  logic [MODE_W-1:0]    req_mode;
  logic                 advance;
  result_t              core_result;
  result_t              res;

  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  pmva_vote #(
    .NUM_USERS(NUM_USERS),
    .NUM_MODES(NUM_MODES)
  ) u_vote (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .user_id    (req_user),
    .wanted_mode(req_mode),
    .result     (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        req_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      req_user <= user_id;
      req_mode <= wanted_mode;
    end
    if (advance) begin
      res <= core_result;
    end
  end

  assign status       = res.status;
  assign clock_update = res.clock_update;
  assign clock_level  = res.clock_level;
  assign working_mode = res.working_mode;

endmodule

`default_nettype wire
